// ----- sv/tbt_pkg.sv -----
// tbt_pkg: shared types and constants of the thermocouple thermostat
// depends on nothing; imported by every module of the block
package tbt_pkg;

	// item kinds carried in s_tuser
	typedef enum logic [1:0] {
		OP_TURN   = 2'd0,
		OP_BUTTON = 2'd1,
		OP_SAMPLE = 2'd2,
		OP_TICK   = 2'd3
	} tbt_op_t;

	// configuration register indexes
	localparam logic [1:0] REG_MAX_TARGET = 2'd0;
	localparam logic [1:0] REG_HOLD_TICKS = 2'd1;
	localparam logic [1:0] REG_LED_LEVEL  = 2'd2;

	localparam logic [7:0]  MAX_TARGET_RST = 8'd200;
	localparam logic [15:0] HOLD_TICKS_RST = 16'd3000;
	localparam logic [7:0]  LED_LEVEL_RST  = 8'd10;

	// display digit codes
	localparam logic [3:0] DIG_DASH  = 4'hA;
	localparam logic [3:0] DIG_BLANK = 4'hF;

	// frame layout
	localparam int OPEN_BIT = 2;

	// display wraps at this many tenths
	localparam logic [13:0] TENTHS_WRAP = 14'd10000;

	typedef struct packed {
		tbt_op_t     op;
		logic        turn_down;
		logic [15:0] raw_frame;
	} tbt_item_t;

	typedef struct packed {
		logic [3:0] thousands;
		logic [3:0] hundreds;
		logic [3:0] tens;
		logic [3:0] ones;
		logic       point;
	} tbt_digits_t;

	typedef struct packed {
		logic        relay_on;
		logic [7:0]  led_red;
		logic [7:0]  led_green;
		logic [7:0]  led_blue;
		tbt_digits_t digits;
		logic [7:0]  target_value;
		logic        relay_allowed;
	} tbt_result_t;

endpackage

// ----- sv/tbt_digits.sv -----
// tbt_digits: splits a tenths-of-a-degree value into four display digits
// uses tbt_pkg; reciprocal multiplies in place of dividers
module tbt_digits (
	input  logic [13:0]          tenths,
	output tbt_pkg::tbt_digits_t digits
);
	import tbt_pkg::*;

	logic [13:0] v;
	logic [27:0] prod_k;
	logic [26:0] prod_h;
	logic [26:0] prod_t;
	logic [3:0]  d0;
	logic [6:0]  h_all;
	logic [9:0]  t_all;
	logic [6:0]  d1_w;
	logic [9:0]  d2_w;
	logic [13:0] d3_w;

	// wrap at 1000.0 degrees, input never reaches twice the wrap
	assign v = (tenths >= TENTHS_WRAP) ? tenths - TENTHS_WRAP : tenths;

	// v/1000, v/100 and v/10 side by side, exact for v below 10000
	assign prod_k = {14'd0, v} * 28'd8389;
	assign prod_h = {13'd0, v} * 27'd5243;
	assign prod_t = {13'd0, v} * 27'd6554;

	assign d0    = prod_k[26:23];
	assign h_all = prod_h[25:19];
	assign t_all = prod_t[25:16];

	assign d1_w = h_all - {d0, 3'b000} - {2'b00, d0, 1'b0};
	assign d2_w = t_all - {h_all, 3'b000} - {2'b00, h_all, 1'b0};
	assign d3_w = v - {1'b0, t_all, 3'b000} - {3'b000, t_all, 1'b0};

	always_comb begin
		digits.thousands = (d0 != 4'd0) ? d0 : DIG_BLANK;
		digits.hundreds  = (d0 != 4'd0 || d1_w[3:0] != 4'd0) ? d1_w[3:0] : DIG_BLANK;
		digits.tens      = d2_w[3:0];
		digits.ones      = d3_w[3:0];
		digits.point     = 1'b1;
	end

endmodule

// ----- sv/tbt_ctrl.sv -----
// tbt_ctrl: thermostat state, configuration registers and per-item update
// uses tbt_pkg and tbt_digits
module tbt_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_idx,
	input  logic [15:0]           cfg_wdata,
	input  logic                  step,
	input  tbt_pkg::tbt_item_t    item,
	output tbt_pkg::tbt_result_t  result
);
	import tbt_pkg::*;

	logic [7:0]  max_target_q;
	logic [15:0] hold_ticks_q;
	logic [7:0]  led_level_q;

	logic [7:0]  target_q;
	logic        permit_q;
	logic [15:0] hold_q;
	logic        relay_q;
	logic [7:0]  red_q;
	logic [7:0]  green_q;
	logic [7:0]  blue_q;
	tbt_digits_t digits_q;

	logic [7:0]  target_step;
	logic [11:0] quarters;
	logic        probe_open;
	logic        holding;
	logic        heat;
	logic [13:0] tenths;
	tbt_digits_t split;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_target_q <= MAX_TARGET_RST;
			hold_ticks_q <= HOLD_TICKS_RST;
			led_level_q  <= LED_LEVEL_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_MAX_TARGET: max_target_q <= cfg_wdata[7:0];
				REG_HOLD_TICKS: hold_ticks_q <= cfg_wdata;
				REG_LED_LEVEL:  led_level_q  <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (item.turn_down)
			target_step = (target_q == 8'd0) ? 8'd0 : target_q - 8'd1;
		else
			target_step = (target_q == 8'hFF) ? 8'hFF : target_q + 8'd1;
		if (target_step > max_target_q)
			target_step = max_target_q;
	end

	assign quarters   = item.raw_frame[14:3];
	assign probe_open = item.raw_frame[OPEN_BIT];
	assign holding    = (hold_q != 16'd0);
	assign heat       = ({2'b00, quarters} < {4'd0, target_q, 2'b00}) && permit_q;

	// target times ten while holding, else quarters times five halves
	assign tenths = holding
		? ({6'd0, target_q} << 3) + ({6'd0, target_q} << 1)
		: 14'(({3'd0, quarters, 2'b00} + {3'd0, 2'b00, quarters}) >> 1);

	tbt_digits u_digits (
		.tenths (tenths),
		.digits (split)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= 8'd0;
			permit_q <= 1'b0;
			hold_q   <= 16'd0;
			relay_q  <= 1'b0;
			red_q    <= 8'd0;
			green_q  <= 8'd0;
			blue_q   <= LED_LEVEL_RST;
			digits_q <= '{DIG_BLANK, DIG_BLANK, DIG_BLANK, DIG_BLANK, 1'b0};
		end else if (step) begin
			unique case (item.op)
				OP_TURN: begin
					target_q <= target_step;
					hold_q   <= hold_ticks_q;
				end
				OP_BUTTON: permit_q <= ~permit_q;
				OP_SAMPLE: begin
					if (holding) begin
						relay_q  <= 1'b0;
						red_q    <= led_level_q;
						green_q  <= led_level_q;
						blue_q   <= led_level_q;
						digits_q <= split;
					end else if (probe_open) begin
						relay_q  <= 1'b0;
						red_q    <= 8'd0;
						green_q  <= 8'd0;
						blue_q   <= 8'd0;
						digits_q <= '{DIG_DASH, DIG_DASH, DIG_DASH, DIG_DASH, 1'b0};
					end else begin
						relay_q  <= heat;
						red_q    <= heat ? led_level_q : 8'd0;
						green_q  <= 8'd0;
						blue_q   <= 8'd0;
						digits_q <= split;
					end
				end
				OP_TICK: if (holding) hold_q <= hold_q - 16'd1;
				default: ;
			endcase
		end
	end

	always_comb begin
		result.relay_on      = relay_q;
		result.led_red       = red_q;
		result.led_green     = green_q;
		result.led_blue      = blue_q;
		result.digits        = digits_q;
		result.target_value  = target_q;
		result.relay_allowed = permit_q;
	end

endmodule

// ----- sv/thermocouple_bang_bang_thermostat_unit.sv -----
// thermocouple_bang_bang_thermostat_unit: top level of the thermostat
// uses tbt_pkg and tbt_ctrl
// a result beat goes valid once its input beat has passed the input register and then the result stage
// throughput: one beat per cycle while the result stream takes each result, as tbt_ctrl updates its state per beat
// the state registers double as the result register and hold still while a result waits
// reset: arst_n resets all control state at once, target 0, relay off, display blank, blue led at LED_LEVEL_RST
module thermocouple_bang_bang_thermostat_unit (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [15:0] cfg_wdata,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // turn_down [0], raw_frame [16:1], zero pad [23:17]
	input  logic [1:0]  s_tuser,   // op [1:0]
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// relay_on [0], led_red [8:1], led_green [16:9], led_blue [24:17],
	// digit_thousands [28:25], digit_hundreds [32:29], digit_tens [36:33],
	// digit_ones [40:37], point_on [41], target_value [49:42], relay_allowed [50],
	// zero pad [55:51]
	output logic [55:0] m_tdata,
	output logic        m_tuser    // display_update [0]
);
	import tbt_pkg::*;

	// input register stage
	logic      valid_s1;
	tbt_item_t item_s1;

	// result stage: valid and update flag, fields come straight from the state
	logic      valid_s2;
	logic      update_s2;

	logic        advance;
	logic        step;
	tbt_result_t result;

	// the pipeline moves whenever the result slot is empty or being emptied
	assign advance  = !valid_s2 || m_tready;
	assign step     = advance && valid_s1;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// payload register, no reset needed
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.op        <= tbt_op_t'(s_tuser);
			item_s1.turn_down <= s_tdata[0];
			item_s1.raw_frame <= s_tdata[16:1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2  <= 1'b0;
			update_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2  <= valid_s1;
			update_s2 <= (item_s1.op == OP_SAMPLE);
		end
	end

	// state, configuration and per-item update
	tbt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.step      (step),
		.item      (item_s1),
		.result    (result)
	);

	assign m_tvalid = valid_s2;
	assign m_tuser  = update_s2;
	assign m_tdata  = {5'd0,
		result.relay_allowed,
		result.target_value,
		result.digits.point,
		result.digits.ones,
		result.digits.tens,
		result.digits.hundreds,
		result.digits.thousands,
		result.led_blue,
		result.led_green,
		result.led_red,
		result.relay_on};

endmodule

// ----- sv/tbt_checker.sv -----
// tbt_checker: port-level assertions on the thermostat, bound to the top level
// uses tbt_pkg
module tbt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata
);
	import tbt_pkg::*;

	// a waiting result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// an energised relay is only ever shown with red alone
	a_relay_red_only: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[24:9] == 16'd0)
		else $error("relay on with green or blue lit");

	// a dark point means a blank or a dashed display
	a_point_off: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[41] |->
			(m_tdata[28:25] == DIG_DASH && m_tdata[32:29] == DIG_DASH &&
			 m_tdata[36:33] == DIG_DASH && m_tdata[40:37] == DIG_DASH) ||
			(m_tdata[28:25] == DIG_BLANK && m_tdata[32:29] == DIG_BLANK &&
			 m_tdata[36:33] == DIG_BLANK && m_tdata[40:37] == DIG_BLANK))
		else $error("point off on a numeric display");

	// no result beat straight out of reset
	a_reset_quiet: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_tvalid)
		else $error("result valid straight after reset");

endmodule

bind thermocouple_bang_bang_thermostat_unit tbt_checker u_tbt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ----- bench/thermostat_readout_checker.sv -----
// thermostat_readout_checker: watches the config port and both streams of the thermostat,
// predicts each result beat from its own copy of the state and compares field by field
// depends on tbt_pkg
module thermostat_readout_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [15:0] cfg_wdata,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,   // turn_down [0], raw_frame [16:1], zero pad [23:17]
	input  logic [1:0]  s_tuser,   // op [1:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [55:0] m_tdata,   // relay_on [0] up to relay_allowed [50], see the block
	input  logic        m_tuser,   // display_update [0]
	output int          mismatch_count,
	output int          readouts_pending
);
	import tbt_pkg::*;

	typedef struct packed {
		tbt_result_t fields;
		logic        display_update;
	} readout_t;

	logic [7:0]  max_target;
	logic [15:0] hold_ticks;
	logic [7:0]  led_level;

	logic [7:0]  target_temp;
	logic        heat_permit;
	logic [15:0] hold_count;
	logic        probe_attached;
	logic        relay_state;
	logic [7:0]  red_level, green_level, blue_level;
	tbt_digits_t shown_digits;

	readout_t readout_q[$];

	// tenths of a degree to four digit codes, leading zeros blanked
	function automatic tbt_digits_t tenths_to_digits(input int unsigned tenths);
		int unsigned v;
		tbt_digits_t d;
		v = tenths % 10000;
		d.thousands = (v / 1000 != 0) ? 4'(v / 1000) : DIG_BLANK;
		d.hundreds  = (v / 100 != 0) ? 4'((v % 1000) / 100) : DIG_BLANK;
		d.tens      = 4'((v % 100) / 10);
		d.ones      = 4'(v % 10);
		d.point     = 1'b1;
		return d;
	endfunction

	task automatic thermostat_next(input tbt_op_t op, input logic down,
			input logic [15:0] frame, output readout_t r);
		int unsigned t;
		int unsigned q;
		q = 32'(frame[14:3]);
		r.display_update = 1'b0;
		case (op)
			OP_TURN: begin
				t = 32'(target_temp);
				if (down)
					t = (t == 0) ? 0 : t - 1;
				else
					t = (t >= 255) ? 255 : t + 1;
				if (t > max_target)
					t = max_target;
				target_temp = 8'(t);
				hold_count  = hold_ticks;
			end
			OP_BUTTON: heat_permit = ~heat_permit;
			OP_SAMPLE: begin
				r.display_update = 1'b1;
				probe_attached   = ~frame[OPEN_BIT];
				if (hold_count != 0) begin
					relay_state  = 1'b0;
					red_level    = led_level;
					green_level  = led_level;
					blue_level   = led_level;
					shown_digits = tenths_to_digits(target_temp * 10);
				end else if (!probe_attached) begin
					relay_state  = 1'b0;
					red_level    = 8'd0;
					green_level  = 8'd0;
					blue_level   = 8'd0;
					shown_digits = '{DIG_DASH, DIG_DASH, DIG_DASH, DIG_DASH, 1'b0};
				end else begin
					shown_digits = tenths_to_digits((q * 5) / 2);
					relay_state  = (q < target_temp * 4) && heat_permit;
					red_level    = relay_state ? led_level : 8'd0;
					green_level  = 8'd0;
					blue_level   = 8'd0;
				end
			end
			OP_TICK: begin
				if (hold_count != 0)
					hold_count = hold_count - 16'd1;
			end
		endcase
		r.fields.relay_on      = relay_state;
		r.fields.led_red       = red_level;
		r.fields.led_green     = green_level;
		r.fields.led_blue      = blue_level;
		r.fields.digits        = shown_digits;
		r.fields.target_value  = target_temp;
		r.fields.relay_allowed = heat_permit;
	endtask

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		readout_t fresh;
		readout_t want;
		if (!arst_n) begin
			max_target     = MAX_TARGET_RST;
			hold_ticks     = HOLD_TICKS_RST;
			led_level      = LED_LEVEL_RST;
			target_temp    = 8'd0;
			heat_permit    = 1'b0;
			hold_count     = 16'd0;
			probe_attached = 1'b0;
			relay_state    = 1'b0;
			red_level      = 8'd0;
			green_level    = 8'd0;
			blue_level     = LED_LEVEL_RST;
			shown_digits   = '{DIG_BLANK, DIG_BLANK, DIG_BLANK, DIG_BLANK, 1'b0};
			readout_q.delete();
			mismatch_count = 0;
			readouts_pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_MAX_TARGET: max_target = cfg_wdata[7:0];
					REG_HOLD_TICKS: hold_ticks = cfg_wdata;
					REG_LED_LEVEL:  led_level  = cfg_wdata[7:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				thermostat_next(tbt_op_t'(s_tuser), s_tdata[0], s_tdata[16:1], fresh);
				readout_q.push_back(fresh);
			end
			if (m_tvalid && m_tready) begin
				if (readout_q.size() == 0) begin
					$error("result beat with no expected result waiting");
					mismatch_count++;
				end else begin
					want = readout_q.pop_front();
					check_field("relay_on", want.fields.relay_on, m_tdata[0]);
					check_field("led_red", want.fields.led_red, m_tdata[8:1]);
					check_field("led_green", want.fields.led_green, m_tdata[16:9]);
					check_field("led_blue", want.fields.led_blue, m_tdata[24:17]);
					check_field("digit_thousands", want.fields.digits.thousands, m_tdata[28:25]);
					check_field("digit_hundreds", want.fields.digits.hundreds, m_tdata[32:29]);
					check_field("digit_tens", want.fields.digits.tens, m_tdata[36:33]);
					check_field("digit_ones", want.fields.digits.ones, m_tdata[40:37]);
					check_field("point_on", want.fields.digits.point, m_tdata[41]);
					check_field("target_value", want.fields.target_value, m_tdata[49:42]);
					check_field("relay_allowed", want.fields.relay_allowed, m_tdata[50]);
					check_field("display_update", want.display_update, m_tuser);
				end
			end
			readouts_pending <= readout_q.size();
		end
	end

endmodule

// ----- bench/tb_top.sv -----
// tb_top: stimulus and verdict for the thermocouple thermostat unit
// depends on tbt_pkg, thermocouple_bang_bang_thermostat_unit and thermostat_readout_checker
// the checker does all prediction and comparison, this module only drives and judges
module tb_top;
	import tbt_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_idx;
	logic [15:0] cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // turn_down [0], raw_frame [16:1], zero pad [23:17]
	logic [1:0]  s_tuser;   // op [1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;   // relay_on [0] up to relay_allowed [50], zero pad above
	logic        m_tuser;   // display_update [0]

	int mismatch_count;
	int readouts_pending;

	// knobs shared between the sender and the receiver process
	bit sender_gaps   = 1'b1;
	bit receiver_gaps = 1'b1;
	int holdoff_cycles = 0;
	int beats_sent     = 0;
	int settings_count = 0;

	thermocouple_bang_bang_thermostat_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	thermostat_readout_checker i_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_idx          (cfg_idx),
		.cfg_wdata        (cfg_wdata),
		.s_tvalid         (s_tvalid),
		.s_tready         (s_tready),
		.s_tdata          (s_tdata),
		.s_tuser          (s_tuser),
		.m_tvalid         (m_tvalid),
		.m_tready         (m_tready),
		.m_tdata          (m_tdata),
		.m_tuser          (m_tuser),
		.mismatch_count   (mismatch_count),
		.readouts_pending (readouts_pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#400000;
		$display("Simulation FAILED");
		$finish;
	end

	// receiver: random stall bursts, plus a long hold-off on request
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (holdoff_cycles != 0) begin
				m_tready <= 1'b0;
				repeat (holdoff_cycles) @(posedge clk);
				holdoff_cycles = 0;
				m_tready <= 1'b1;
			end else if (receiver_gaps && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// offer one beat, returning at the edge where it is taken; valid stays high
	// into the next beat unless a gap is drawn
	task automatic send_beat(input tbt_op_t op, input logic down, input logic [15:0] frame);
		if (sender_gaps && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {7'd0, frame, down};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		beats_sent++;
	endtask

	// stop sending, wait until every expected result is out, then write all registers
	task automatic settle_and_configure(input logic [7:0] ceiling, input logic [15:0] hold,
			input logic [7:0] level);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (readouts_pending != 0) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= REG_MAX_TARGET;
		cfg_wdata <= {8'd0, ceiling};
		@(posedge clk);
		cfg_idx   <= REG_HOLD_TICKS;
		cfg_wdata <= hold;
		@(posedge clk);
		cfg_idx   <= REG_LED_LEVEL;
		cfg_wdata <= {8'd0, level};
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_count++;
	endtask

	// mostly clean readings around the usable target range, some open probes, some raw noise
	function automatic logic [15:0] sample_frame();
		logic [11:0] q;
		int unsigned pick;
		pick = $urandom_range(0, 9);
		q    = 12'($urandom_range(0, 1023));
		if (pick < 2)
			return 16'($urandom);
		if (pick == 2)
			return {1'($urandom), q, 1'b1, 2'($urandom)};
		return {1'($urandom), q, 1'b0, 2'($urandom)};
	endfunction

	// random mix; turn_pct sets how often the encoder moves, up_pct its direction
	task automatic run_random(input int count, input int turn_pct, input int up_pct);
		tbt_op_t op;
		logic down;
		int unsigned pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < turn_pct) begin
				op = OP_TURN;
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 12)
					op = OP_BUTTON;
				else if (pick < 55)
					op = OP_SAMPLE;
				else
					op = OP_TICK;
			end
			down = (op == OP_TURN) ? ($urandom_range(0, 99) >= up_pct) : 1'($urandom);
			send_beat(op, down, (op == OP_SAMPLE) ? sample_frame() : 16'($urandom));
		end
	endtask

	initial begin
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_idx   <= REG_MAX_TARGET;
		cfg_wdata <= 16'd0;
		s_tvalid  <= 1'b0;
		s_tdata   <= 24'd0;
		s_tuser   <= OP_TICK;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed, reset settings: zero reading, open probe, ignored frame bits
		send_beat(OP_SAMPLE, 1'b0, 16'h0000);
		send_beat(OP_SAMPLE, 1'b0, 16'h0004);
		send_beat(OP_SAMPLE, 1'b1, 16'hFFFB);   // full scale with bit 15 and low bits set, wraps
		send_beat(OP_SAMPLE, 1'b0, 16'h7FF8);
		send_beat(OP_TICK, 1'b0, 16'h0000);     // tick with no hold running
		send_beat(OP_BUTTON, 1'b0, 16'h0000);
		send_beat(OP_TURN, 1'b0, 16'h0000);     // starts the default long hold
		send_beat(OP_SAMPLE, 1'b0, 16'h0000);   // target shown while holding
		send_beat(OP_TURN, 1'b1, 16'h0000);
		send_beat(OP_TURN, 1'b1, 16'hFFFF);     // floor at zero
		send_beat(OP_BUTTON, 1'b1, 16'hFFFF);
		send_beat(OP_TICK, 1'b1, 16'hFFFF);

		// ceiling of zero, no hold, brightest leds
		settle_and_configure(8'd0, 16'd0, 8'd255);
		send_beat(OP_TURN, 1'b0, 16'h0000);     // clamps to zero and cancels the hold
		send_beat(OP_SAMPLE, 1'b0, 16'h0000);
		send_beat(OP_BUTTON, 1'b0, 16'h0000);
		send_beat(OP_SAMPLE, 1'b0, 16'h0004);

		// leds dark, single tick hold
		settle_and_configure(8'd255, 16'd1, 8'd0);
		send_beat(OP_TURN, 1'b0, 16'h0000);
		send_beat(OP_SAMPLE, 1'b0, 16'h0000);
		send_beat(OP_TICK, 1'b0, 16'h0000);     // hold expires
		send_beat(OP_SAMPLE, 1'b0, 16'h0018);   // just below target, relay on
		send_beat(OP_SAMPLE, 1'b0, 16'h0020);   // equal to target, relay off

		// mostly upward turns drive the target toward the top limit
		settle_and_configure(8'd255, 16'd4, 8'd255);
		run_random(420, 60, 95);

		// ceiling lowered under the current target, first turn clamps it
		settle_and_configure(8'd100, 16'd6, 8'd37);
		run_random(300, 25, 50);

		// no hold at all; the receiver stalls for a long stretch while beats keep coming
		settle_and_configure(8'd200, 16'd0, 8'd10);
		holdoff_cycles = 80;
		run_random(380, 25, 50);

		// longest hold, the display stays on the target
		settle_and_configure(8'd255, 16'd65535, 8'd128);
		run_random(100, 25, 60);

		// closing stretch at full rate on both sides
		settle_and_configure(8'd150, 16'd2, 8'd200);
		sender_gaps   = 1'b0;
		receiver_gaps = 1'b0;
		run_random(280, 25, 50);

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (readouts_pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("%0d beats sent over %0d register settings after reset", beats_sent,
			settings_count);
		$display("covered target limits, holds, open probes, display wrap and input stalls");
		if (mismatch_count == 0 && readouts_pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
sv/tbt_pkg.sv
sv/tbt_digits.sv
sv/tbt_ctrl.sv
sv/thermocouple_bang_bang_thermostat_unit.sv
sv/tbt_checker.sv
bench/thermostat_readout_checker.sv
bench/tb_top.sv
